FILE: sv/efl_pkg.sv
`timescale 1ns / 1ps

package efl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int ENV_W    = 24;
    localparam int HOLD_W   = 16;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // register reset values
    localparam logic [COEFF_W-1:0] ATTACK_RST    = 16'd65082;
    localparam logic [COEFF_W-1:0] RELEASE_RST   = 16'd65527;
    localparam logic [15:0]        THRESHOLD_RST = 16'd4096;
    localparam logic [HOLD_W-1:0]  HOLDOFF_RST   = 16'd5760;

    // thresholds at or below this never fire
    localparam logic [15:0] THR_FLOOR = 16'd32;

    // register index (word address)
    typedef enum logic [1:0] {
        REG_ATTACK    = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_HOLDOFF   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [COEFF_W-1:0] attack_coeff;
        logic [COEFF_W-1:0] release_coeff;
        logic [15:0]        threshold_level;
        logic [HOLD_W-1:0]  holdoff_samples;
    } t_cfg;

    typedef struct packed {
        logic        fire;
        logic [15:0] envelope_level;
        logic        latched;
    } t_result;

    // magnitude of a signed sample, -32768 gives 32768
    function automatic logic [SAMPLE_W-1:0] f_mag(input logic signed [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] m;
        begin
            if (s[SAMPLE_W-1]) begin
                m = (~s) + 1'b1;
            end else begin
                m = s;
            end
            return m;
        end
    endfunction

endpackage

FILE: sv/efl_regs.sv
`timescale 1ns / 1ps

module efl_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efl_pkg::ADDR_W-1:0]  paddr,
    input  logic [efl_pkg::DATA_W-1:0]  pwdata,
    output logic [efl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output efl_pkg::t_cfg               o_cfg
);

    efl_pkg::t_cfg     r_cfg;
    efl_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx  = efl_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coeff    <= efl_pkg::ATTACK_RST;
            r_cfg.release_coeff   <= efl_pkg::RELEASE_RST;
            r_cfg.threshold_level <= efl_pkg::THRESHOLD_RST;
            r_cfg.holdoff_samples <= efl_pkg::HOLDOFF_RST;
        end else if (w_wr) begin
            case (w_idx)
                efl_pkg::REG_ATTACK:    r_cfg.attack_coeff    <= pwdata[15:0];
                efl_pkg::REG_RELEASE:   r_cfg.release_coeff   <= pwdata[15:0];
                efl_pkg::REG_THRESHOLD: r_cfg.threshold_level <= pwdata[15:0];
                efl_pkg::REG_HOLDOFF:   r_cfg.holdoff_samples <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            efl_pkg::REG_ATTACK:    prdata = {16'd0, r_cfg.attack_coeff};
            efl_pkg::REG_RELEASE:   prdata = {16'd0, r_cfg.release_coeff};
            efl_pkg::REG_THRESHOLD: prdata = {16'd0, r_cfg.threshold_level};
            efl_pkg::REG_HOLDOFF:   prdata = {16'd0, r_cfg.holdoff_samples};
            default:                prdata = '0;
        endcase
    end

endmodule

FILE: sv/efl_core.sv
`timescale 1ns / 1ps

module efl_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [efl_pkg::SAMPLE_W-1:0]  i_mag,
    input  efl_pkg::t_cfg                 i_cfg,
    output efl_pkg::t_result              o_res
);

    logic [efl_pkg::ENV_W-1:0]   r_env;
    logic                        r_latched;
    logic [efl_pkg::HOLD_W-1:0]  r_holdoff;
    efl_pkg::t_result            r_res;

    logic [efl_pkg::ENV_W-1:0]   w_x;
    logic [efl_pkg::COEFF_W-1:0] w_c;
    logic signed [24:0]          w_diff;
    logic signed [41:0]          w_prod;
    logic signed [41:0]          w_acc;
    logic [efl_pkg::ENV_W-1:0]   n_env;
    logic [efl_pkg::HOLD_W-1:0]  w_hold_dec;
    logic                        w_rearm;
    logic                        w_latch_mid;
    logic                        n_fire;
    logic                        n_latched;
    logic [efl_pkg::HOLD_W-1:0]  n_holdoff;

    // x = magnitude in Q1.23
    assign w_x = {i_mag, 8'd0};
    assign w_c = (w_x > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;

    // c*env + (1-c)*x folded into x + c*(env - x), one multiplier
    assign w_diff = $signed({1'b0, r_env}) - $signed({1'b0, w_x});
    assign w_prod = $signed({1'b0, w_c}) * w_diff;
    assign w_acc  = $signed({2'b00, w_x, 16'd0}) + w_prod + $signed(42'd32768);
    assign n_env  = w_acc[39:16];

    assign w_hold_dec  = (r_holdoff != '0) ? (r_holdoff - 1'b1) : r_holdoff;
    assign w_rearm     = n_env < {2'b00, i_cfg.threshold_level, 6'd0};
    assign w_latch_mid = r_latched && !w_rearm;

    assign n_fire = !w_latch_mid
                 && (i_cfg.threshold_level > efl_pkg::THR_FLOOR)
                 && (n_env >= {i_cfg.threshold_level, 8'd0})
                 && (w_hold_dec == '0);
    assign n_latched = w_latch_mid || n_fire;
    assign n_holdoff = n_fire ? i_cfg.holdoff_samples : w_hold_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env     <= '0;
            r_latched <= 1'b0;
            r_holdoff <= '0;
            r_res     <= '0;
        end else if (i_step) begin
            r_env                <= n_env;
            r_latched            <= n_latched;
            r_holdoff            <= n_holdoff;
            r_res.fire           <= n_fire;
            r_res.envelope_level <= n_env[23:8];
            r_res.latched        <= n_latched;
        end
    end

    assign o_res = r_res;

    a_fire_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.fire |-> r_res.latched)
        else $error("fire without latch");

    a_env_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= 24'h800000)
        else $error("envelope above full scale");

    a_fire_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_fire) |=> (r_holdoff == $past(i_cfg.holdoff_samples)))
        else $error("hold-off not reloaded on fire");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_env) && $stable(r_holdoff) && $stable(r_latched)))
        else $error("state moved without an item");

endmodule

FILE: sv/envelope_follower_trigger_top.sv
`timescale 1ns / 1ps

// channel   | handshake                | payload
// ----------+--------------------------+----------------------------------------
// input     | i_in_valid / o_in_ready  | i_sample
// output    | o_out_valid / i_out_ready| o_fire, o_envelope_level, o_latched
// config    | psel penable pwrite      | paddr, pwdata, prdata (pready tied high)
//
// one item per cycle unless the output stalls; input register, then result register
// the envelope multiply-add and trigger compares are combinational inside the state loop
// reset is synchronous, active low: envelope, latch and hold-off cleared, registers to defaults
// an output stall holds the result register; the input register still takes one more item

module envelope_follower_trigger_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input item
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [15:0]           i_sample,
    // result item
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_fire,
    output logic [15:0]                  o_envelope_level,
    output logic                         o_latched,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efl_pkg::ADDR_W-1:0]   paddr,
    input  logic [efl_pkg::DATA_W-1:0]   pwdata,
    output logic [efl_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    efl_pkg::t_cfg                 w_cfg;
    efl_pkg::t_result              w_res;

    logic                          r_s1_valid;
    logic [efl_pkg::SAMPLE_W-1:0]  r_mag;
    logic                          r_out_valid;
    logic                          w_adv;
    logic                          w_step;

    // result register free, or being emptied this cycle
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_step     = r_s1_valid && w_adv;
    assign o_in_ready = !r_s1_valid || w_adv;

    // input register: rectified sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mag <= efl_pkg::f_mag(i_sample);
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    efl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // envelope follower, hold-off and trigger state; holds the result register
    efl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_mag   (r_mag),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_fire           = w_res.fire;
    assign o_envelope_level = w_res.envelope_level;
    assign o_latched        = w_res.latched;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_mag)))
        else $error("pending item lost in input register");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("result register not filled after step");

endmodule

FILE: verif/envelope_follower_trigger_top_tb.sv
`timescale 1ns / 1ps

module envelope_follower_trigger_top_tb;
    import efl_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RESET_CYCLES  = 11;
    localparam int LONG_STALL    = 300;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 205;
    // two register stages in the block, plus some slack
    localparam int SETTLE_CYCLES = 6;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_in_valid       = 1'b0;
    logic                     o_in_ready;
    logic signed [15:0]       i_sample         = '0;
    logic                     o_out_valid;
    logic                     i_out_ready      = 1'b0;
    logic                     o_fire;
    logic [15:0]              o_envelope_level;
    logic                     o_latched;
    logic                     psel             = 1'b0;
    logic                     penable          = 1'b0;
    logic                     pwrite           = 1'b0;
    logic [ADDR_W-1:0]        paddr            = '0;
    logic [DATA_W-1:0]        pwdata           = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    envelope_follower_trigger_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_fire           (o_fire),
        .o_envelope_level (o_envelope_level),
        .o_latched        (o_latched),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the register file, updated as each write completes
    t_cfg              cfg_m;
    // follower state as the block should hold it
    logic [ENV_W-1:0]  env_acc;
    logic              trig_latched;
    logic [HOLD_W-1:0] holdoff_left;

    // samples waiting for the driver, and results waiting for the block
    logic [15:0]       sample_q[$];
    t_result           env_expect_q[$];

    int unsigned n_queued = 0;
    int unsigned n_taken  = 0;
    int unsigned n_seen   = 0;
    int unsigned n_errors = 0;
    int unsigned cycle_cnt = 0;

    logic        rst_done = 1'b0;
    // input item taken at the last rising edge
    logic        in_taken = 1'b0;

    // long receiver hold-off, requested by the sequence and served by the receiver
    int unsigned stall_req_n  = 0;
    int unsigned stall_seen_n = 0;

    int unsigned in_gap    = 0;
    int unsigned in_burst  = 0;
    int unsigned rdy_gap   = 0;
    int unsigned rdy_burst = 0;
    int unsigned hold_left = 0;

    // one sample through the follower: rectify, one-pole step, hold-off, re-arm, fire
    function automatic t_result follow_envelope(input logic [15:0] raw);
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] c;
        logic [63:0] acc;
        t_result     r;
        // -32768 rectifies to 32768
        mag = raw[15] ? (64'h10000 - 64'(raw)) : 64'(raw);
        x   = mag << 8;
        // attack pole while the magnitude is above the envelope
        c   = (x > 64'(env_acc)) ? 64'(cfg_m.attack_coeff) : 64'(cfg_m.release_coeff);
        // exact product sum, rounded half up
        acc = c * 64'(env_acc) + (64'd65536 - c) * x + 64'd32768;
        env_acc = acc[ENV_W+15:16];
        if (holdoff_left != '0) begin
            holdoff_left = holdoff_left - 1'b1;
        end
        // re-arm once the envelope drops under a quarter of the threshold
        if (trig_latched && (32'(env_acc) < (32'(cfg_m.threshold_level) << 6))) begin
            trig_latched = 1'b0;
        end
        r.fire = 1'b0;
        // thresholds at the floor or below never fire
        if (!trig_latched && (cfg_m.threshold_level > THR_FLOOR) &&
            (32'(env_acc) >= (32'(cfg_m.threshold_level) << 8)) && (holdoff_left == '0)) begin
            r.fire       = 1'b1;
            trig_latched = 1'b1;
            holdoff_left = cfg_m.holdoff_samples;
        end
        r.envelope_level = env_acc[ENV_W-1:8];
        r.latched        = trig_latched;
        return r;
    endfunction

    function automatic void compare_result(input t_result got);
        t_result want;
        if (env_expect_q.size() == 0) begin
            n_errors++;
            $display("%0t: result item with nothing expected, actual fire %0d env %0d latched %0d",
                     $time, got.fire, got.envelope_level, got.latched);
            return;
        end
        want = env_expect_q.pop_front();
        if (got.fire !== want.fire) begin
            n_errors++;
            $display("%0t: fire mismatch, expected %0d, actual %0d",
                     $time, want.fire, got.fire);
        end
        if (got.envelope_level !== want.envelope_level) begin
            n_errors++;
            $display("%0t: envelope_level mismatch, expected %0d, actual %0d",
                     $time, want.envelope_level, got.envelope_level);
        end
        if (got.latched !== want.latched) begin
            n_errors++;
            $display("%0t: latched mismatch, expected %0d, actual %0d",
                     $time, want.latched, got.latched);
        end
    endfunction

    // idle length: mostly none or short, now and then long, with bursts of no idling
    function automatic int unsigned idle_len(inout int unsigned burst_left);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_left != 0) begin
            burst_left = burst_left - 1;
            return 0;
        end
        if (r < 3) begin
            burst_left = $urandom_range(50, 200);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // monitor: sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (rst_done) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                env_expect_q.push_back(follow_envelope(i_sample));
                n_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                compare_result({o_fire, o_envelope_level, o_latched});
                n_seen++;
            end
        end
    end

    // sender: a valid item is held until taken, then an optional gap
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // item still on offer
        end else if (in_gap != 0) begin
            i_in_valid <= 1'b0;
            in_gap = in_gap - 1;
        end else if (sample_q.size() != 0) begin
            i_in_valid <= 1'b1;
            i_sample   <= sample_q.pop_front();
            in_gap = idle_len(in_burst);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: random ready gaps, plus the long hold-off when asked
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_seen_n != stall_req_n) begin
            stall_seen_n = stall_req_n;
            hold_left    = LONG_STALL - 1;
            i_out_ready <= 1'b0;
        end else if (rdy_gap != 0) begin
            i_out_ready <= 1'b0;
            rdy_gap = rdy_gap - 1;
        end else begin
            i_out_ready <= 1'b1;
            rdy_gap = idle_len(rdy_burst);
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // setup then access; upper data bits carry junk that the block must ignore
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ATTACK:    cfg_m.attack_coeff    = val;
            REG_RELEASE:   cfg_m.release_coeff   = val;
            REG_THRESHOLD: cfg_m.threshold_level = val;
            REG_HOLDOFF:   cfg_m.holdoff_samples = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] att, input logic [15:0] rel,
                                input logic [15:0] thr, input logic [15:0] hold);
        write_reg(REG_ATTACK, att);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_HOLDOFF, hold);
    endtask

    task automatic push_sample(input logic [15:0] s);
        sample_q.push_back(s);
        n_queued++;
    endtask

    // block idle: every queued item taken, every result back, pipeline settled
    task automatic wait_idle();
        while ((n_taken != n_queued) || (n_seen != n_taken)) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_pole();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        if (r < 70) return 16'($urandom_range(30000, 64000));
        return 16'($urandom_range(0, 65535));
    endfunction

    // random configuration, then bursts and silences so the trigger cycles through
    // fire, latch and re-arm; some noise and extremes mixed in
    task automatic random_phase(input int unsigned n_items);
        int unsigned left;
        int unsigned seg;
        int unsigned kind;
        int unsigned r;
        logic [15:0] thr;
        logic [15:0] hold;
        logic [16:0] m;
        r = $urandom_range(0, 99);
        if (r < 10)      thr = 16'($urandom_range(0, 32));
        else if (r < 15) thr = 16'd33;
        else if (r < 20) thr = 16'd32768;
        else if (r < 25) thr = 16'($urandom_range(32769, 65535));
        else             thr = 16'($urandom_range(256, 16384));
        r = $urandom_range(0, 99);
        if (r < 25)      hold = 16'd0;
        else if (r < 70) hold = 16'($urandom_range(1, 30));
        else if (r < 95) hold = 16'($urandom_range(31, 300));
        else             hold = 16'($urandom_range(301, 6000));
        apply_config(pick_pole(), pick_pole(), thr, hold);
        left = n_items;
        while (left != 0) begin
            kind = $urandom_range(0, 99);
            if (kind < 35)      seg = $urandom_range(3, 30);
            else if (kind < 70) seg = $urandom_range(5, 60);
            else if (kind < 90) seg = $urandom_range(1, 10);
            else                seg = $urandom_range(1, 4);
            if (seg > left) seg = left;
            left = left - seg;
            repeat (seg) begin
                if (kind >= 70 && kind < 90) begin
                    // noise over the whole range
                    push_sample(16'($urandom));
                end else begin
                    if (kind < 35) begin
                        m = 17'($urandom_range(8000, 32768));
                    end else if (kind < 70) begin
                        // quiet enough to re-arm
                        m = 17'($urandom_range(0, cfg_m.threshold_level >> 3));
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       m = 17'd0;
                            1:       m = 17'd1;
                            2:       m = 17'd32767;
                            default: m = 17'd32768;
                        endcase
                    end
                    push_sample($urandom_range(0, 1) ? 16'(17'h10000 - m) : m[15:0]);
                end
            end
        end
    endtask

    initial begin
        cfg_m.attack_coeff    = ATTACK_RST;
        cfg_m.release_coeff   = RELEASE_RST;
        cfg_m.threshold_level = THRESHOLD_RST;
        cfg_m.holdoff_samples = HOLDOFF_RST;
        env_acc      = '0;
        trig_latched = 1'b0;
        holdoff_left = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // register defaults: slow attack from silence, full scale both signs
        push_sample(16'sd32767);
        push_sample(16'sd32767);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(16'sd0);
        push_sample(-16'sd1);
        wait_idle();

        // zero poles: envelope jumps to the magnitude, no hold-off
        apply_config(16'd0, 16'd0, 16'd4096, 16'd0);
        push_sample(16'sd8000);     // fires
        push_sample(16'sd8000);     // still latched
        push_sample(16'sd1023);     // just under a quarter, re-arms
        push_sample(-16'sd4096);    // exactly at threshold, fires
        push_sample(-16'sd32768);
        push_sample(16'sd0);        // re-arms
        push_sample(16'sd32767);    // fires
        wait_idle();

        // threshold at the floor: never fires, re-arm still works
        apply_config(16'd0, 16'd0, THR_FLOOR, 16'd3);
        push_sample(16'sd32767);
        push_sample(16'sd0);
        push_sample(16'sd32767);
        wait_idle();

        // one above the floor, with hold-off gating a second fire
        write_reg(REG_THRESHOLD, 16'd33);
        push_sample(16'sd33);
        push_sample(16'sd0);
        push_sample(16'sd33);
        push_sample(16'sd33);
        wait_idle();

        // slowest poles, threshold beyond full scale, longest hold-off
        apply_config(16'hFFFF, 16'hFFFF, 16'd40000, 16'hFFFF);
        push_sample(-16'sd32768);
        push_sample(16'sd32767);
        wait_idle();

        // full-scale threshold reached only by -32768
        apply_config(16'd0, 16'd0, 16'd32768, 16'd0);
        push_sample(16'sd0);
        push_sample(-16'sd32768);
        push_sample(16'sd32767);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            // one phase starts with the receiver held off so the block backs up
            if (p == 2) stall_req_n <= stall_req_n + 1;
            random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (env_expect_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d result items expected but never seen, actual none",
                     $time, env_expect_q.size());
        end
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
